### hdl/fcf_pkg.sv
// Package for the frame channel filter: frame geometry, CRC-32 constants,
// configuration register indexes, shared types and the byte-wide CRC update.
// No dependencies.
package fcf_pkg;

    // Frame geometry
    localparam int FRAME_BYTES    = 223;
    localparam int HEADER_BYTES   = 5;
    localparam int CRC_DATA_BYTES = 214;

    localparam int POS_W = 8;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Region bounds, one bit wider than the position so that the trailer end never wraps
    localparam logic [POS_W:0] CRC_LO   = (POS_W+1)'(HEADER_BYTES);
    localparam logic [POS_W:0] CRC_HI   = (POS_W+1)'(HEADER_BYTES + CRC_DATA_BYTES);
    localparam logic [POS_W:0] TRL_HI   = (POS_W+1)'(HEADER_BYTES + CRC_DATA_BYTES + 4);
    localparam logic [POS_W-1:0] FRAME_LEN = POS_W'(FRAME_BYTES);

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] CRC_XOROUT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_START_RESET = 32'h6AAA_C1C5;

    localparam logic [2:0] WANTED_CHAN_RESET = 3'd1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CRC_START   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WANTED_CHAN = 2'd1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_item_t;

    typedef struct packed {
        logic [15:0] spacecraft_word;
        logic [2:0]  channel_id;
        logic        channel_match;
        logic        length_ok;
        logic        crc_ok;
    } result_t;

    // One byte through the reflected CRC-32: a fixed XOR network
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] v;
        v = {24'd0, crc[7:0] ^ b};
        for (int i = 0; i < 8; i++) begin
            v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
        end
        return (crc >> 8) ^ v;
    endfunction

endpackage

### hdl/fcf_in_reg.sv
// Input register for the frame channel filter: holds one byte transaction
// until the frame tracker takes it. Depends on fcf_pkg.
module fcf_in_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  fcf_pkg::byte_item_t in_item,
    input  logic               move,
    output logic               stall,
    output logic               hold_valid,
    output fcf_pkg::byte_item_t hold_item
);

    logic               valid_reg;
    logic               valid_next;
    fcf_pkg::byte_item_t item_reg;
    logic               load;

    // Stall only while a held byte cannot move on
    assign stall = valid_reg && !move;
    assign load  = in_valid && !stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (move)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on every accepted transaction
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_item  = item_reg;

endmodule

### hdl/fcf_frame_track.sv
// Frame tracker: byte position, header word, CRC register and trailer word,
// and the per-frame verdict at the last byte. Depends on fcf_pkg.
module fcf_frame_track (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  fcf_pkg::byte_item_t item,
    input  logic [31:0]         crc_start,
    input  logic [2:0]          wanted_chan,
    output fcf_pkg::result_t    res
);

    logic [fcf_pkg::POS_W-1:0] pos_reg;
    logic [fcf_pkg::POS_W-1:0] pos_next;
    logic [fcf_pkg::POS_W-1:0] count;
    logic [15:0] hdr_reg;
    logic [15:0] hdr_next;
    logic [31:0] crc_reg;
    logic [31:0] crc_cur;
    logic [31:0] crc_next;
    logic [31:0] trl_reg;
    logic [31:0] trl_cur;
    logic [31:0] trl_next;
    logic [fcf_pkg::POS_W:0] pos_ext;
    logic        first;
    logic        in_crc;
    logic        in_trl;
    logic        len_ok;

    assign first   = (pos_reg == '0);
    assign pos_ext = {1'b0, pos_reg};
    assign in_crc  = (pos_ext >= fcf_pkg::CRC_LO) && (pos_ext < fcf_pkg::CRC_HI);
    assign in_trl  = (pos_ext >= fcf_pkg::CRC_HI) && (pos_ext < fcf_pkg::TRL_HI);

    // Restart the running values at the first byte of a frame
    assign crc_cur = first ? crc_start : crc_reg;
    assign trl_cur = first ? 32'd0 : trl_reg;

    always_comb
    begin
        hdr_next = hdr_reg;
        if (first)
        begin
            hdr_next = {item.data, 8'd0};
        end
        else if (pos_reg == fcf_pkg::POS_W'(1))
        begin
            hdr_next = {hdr_reg[15:8], item.data};
        end
    end

    assign crc_next = in_crc ? fcf_pkg::crc_byte(crc_cur, item.data) : crc_cur;
    assign trl_next = in_trl ? {trl_cur[23:0], item.data} : trl_cur;

    // Saturating byte count, cleared after the last byte
    assign count    = (pos_reg == fcf_pkg::POS_MAX) ? pos_reg : pos_reg + 1'b1;
    assign pos_next = item.last ? '0 : count;

    assign len_ok = (count == fcf_pkg::FRAME_LEN);

    // Verdict for the frame that ends with this byte
    always_comb
    begin
        res.spacecraft_word = hdr_next;
        res.channel_id      = hdr_next[3:1];
        res.channel_match   = (hdr_next[3:1] == wanted_chan);
        res.length_ok       = len_ok;
        res.crc_ok          = len_ok && ((crc_next ^ fcf_pkg::CRC_XOROUT) == trl_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hdr_reg <= hdr_next;
            crc_reg <= crc_next;
            trl_reg <= trl_next;
        end
    end

    // A frame end always returns the position to the frame start
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.last |=> pos_reg == '0)
        else $error("position not cleared after frame end");

    // The count never wraps back to zero inside a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !item.last |=> pos_reg != '0)
        else $error("position wrapped inside a frame");

    // Position moves only on an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(pos_reg))
        else $error("position changed without a byte");

endmodule

### hdl/fcf_out_reg.sv
// Result register for the frame channel filter: holds one verdict until the
// receiver takes it. Depends on fcf_pkg.
module fcf_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  fcf_pkg::result_t res_in,
    input  logic             out_stall,
    output logic             busy,
    output logic             out_valid,
    output fcf_pkg::result_t res_out
);

    logic             valid_reg;
    logic             valid_next;
    fcf_pkg::result_t res_reg;

    assign busy = valid_reg && out_stall;

    // Hold a stalled verdict, drop it once taken
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

    // A new verdict never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !busy)
        else $error("verdict overwritten while stalled");

    // A reported CRC pass implies a correct length
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (!res_reg.crc_ok || res_reg.length_ok))
        else $error("crc_ok without length_ok");

    // The channel field is always taken from the spacecraft word
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> res_reg.channel_id == res_reg.spacecraft_word[3:1])
        else $error("channel_id inconsistent with spacecraft_word");

endmodule

### hdl/frame_channel_filter_crc32_check.sv
// A byte is held in the input register until the frame tracker processes it; a verdict
// is registered in the result register when the last byte of a frame is processed.
// Throughput: one byte per cycle; input stalls only when a last byte meets a
// verdict still held by a stalled receiver (one result register).
// Reset: asynchronous, active low; clears valids and the byte position and
// loads crc_start_value 0x6AAAC1C5 and wanted_channel 1. Depends on fcf_pkg.
module frame_channel_filter_crc32_check (
    input  logic                          clk,
    input  logic                          rst_n,
    // Configuration write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fcf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    // Byte input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    data_byte,
    input  logic                          last_byte,
    // Verdict output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [15:0]                   spacecraft_word,
    output logic [2:0]                    channel_id,
    output logic                          channel_match,
    output logic                          length_ok,
    output logic                          crc_ok
);

    logic [31:0]         crc_start_reg;
    logic [2:0]          wanted_chan_reg;
    fcf_pkg::byte_item_t in_item;
    fcf_pkg::byte_item_t hold_item;
    logic                hold_valid;
    logic                move;
    logic                advance;
    logic                out_busy;
    fcf_pkg::result_t    res_comb;
    fcf_pkg::result_t    res_out;

    // Configuration registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_start_reg   <= fcf_pkg::CRC_START_RESET;
            wanted_chan_reg <= fcf_pkg::WANTED_CHAN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fcf_pkg::CFG_CRC_START:   crc_start_reg   <= cfg_data;
                fcf_pkg::CFG_WANTED_CHAN: wanted_chan_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign in_item.data = data_byte;
    assign in_item.last = last_byte;

    // A held byte moves on unless it ends a frame and the verdict slot is blocked
    assign move    = !hold_item.last || !out_busy;
    assign advance = hold_valid && move;

    fcf_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_item    (in_item),
        .move       (move),
        .stall      (in_stall),
        .hold_valid (hold_valid),
        .hold_item  (hold_item)
    );

    fcf_frame_track u_frame_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .item        (hold_item),
        .crc_start   (crc_start_reg),
        .wanted_chan (wanted_chan_reg),
        .res         (res_comb)
    );

    fcf_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && hold_item.last),
        .res_in    (res_comb),
        .out_stall (out_stall),
        .busy      (out_busy),
        .out_valid (out_valid),
        .res_out   (res_out)
    );

    assign spacecraft_word = res_out.spacecraft_word;
    assign channel_id      = res_out.channel_id;
    assign channel_match   = res_out.channel_match;
    assign length_ok       = res_out.length_ok;
    assign crc_ok          = res_out.crc_ok;

    // Input stalls only for a frame end blocked by a waiting verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> hold_valid && hold_item.last && out_valid && out_stall)
        else $error("input stalled without a blocked frame end");

    // A processed frame end shows a verdict on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && hold_item.last |=> out_valid)
        else $error("frame end produced no verdict");

    // A verdict appears only after a frame end was processed
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(advance && hold_item.last))
        else $error("verdict without a frame end");

endmodule

### tb/frame_channel_filter_crc32_check_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for frame_channel_filter_crc32_check: queues byte frames,
// predicts every verdict with an independent CRC-32 frame model and compares each field.
// Depends on fcf_pkg and the frame_channel_filter_crc32_check RTL.
module frame_channel_filter_crc32_check_tb;

    // Register indexes with no register behind them
    localparam logic [fcf_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [fcf_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 6;
    localparam int NUM_PHASES    = 4;
    localparam int PHASE_BYTES   = 230;

    typedef struct {
        logic [7:0] value;
        logic       tail;
        int         pre_gap;
    } byte_slot_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic [fcf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic [7:0]                    data_byte = '0;
    logic                          last_byte = 1'b0;
    logic                          out_stall = 1'b0;
    logic                          cfg_ready;
    logic                          in_stall;
    logic                          out_valid;
    logic [15:0]                   spacecraft_word;
    logic [2:0]                    channel_id;
    logic                          channel_match;
    logic                          length_ok;
    logic                          crc_ok;

    // Frame model state and its copy of the registers
    logic [31:0] start_shadow = fcf_pkg::CRC_START_RESET;
    logic [2:0]  chan_shadow  = fcf_pkg::WANTED_CHAN_RESET;
    logic [31:0] run_crc      = fcf_pkg::CRC_START_RESET;
    logic [7:0]  frame_pos    = '0;
    logic [15:0] hdr_word     = '0;
    logic [31:0] trl_word     = '0;

    byte_slot_t       pending_bytes[$];
    fcf_pkg::result_t expected_verdicts[$];

    bit tx_gaps       = 1'b0;
    bit rx_gaps       = 1'b0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int rx_wait       = 0;
    int tx_wait       = 0;
    int quiet_cycles  = 0;
    int fault_count   = 0;
    int queued_bytes  = 0;

    frame_channel_filter_crc32_check i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .spacecraft_word (spacecraft_word),
        .channel_id      (channel_id),
        .channel_match   (channel_match),
        .length_ok       (length_ok),
        .crc_ok          (crc_ok)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reflected CRC-32, one bit at a time
    function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
            r = r[0] ? ((r >> 1) ^ fcf_pkg::CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // Advance the frame model by one accepted byte; queue a verdict on the last one
    task automatic absorb_byte(input logic [7:0] b, input logic tail);
        fcf_pkg::result_t v;
        logic [2:0]       chan;
        if (frame_pos == 8'd0)
        begin
            run_crc  = start_shadow;
            hdr_word = {b, 8'h00};
            trl_word = '0;
        end
        else if (frame_pos == 8'd1)
            hdr_word[7:0] = b;

        if (frame_pos >= fcf_pkg::HEADER_BYTES
            && frame_pos < fcf_pkg::HEADER_BYTES + fcf_pkg::CRC_DATA_BYTES)
            run_crc = crc32_update(run_crc, b);
        else if (frame_pos >= fcf_pkg::HEADER_BYTES + fcf_pkg::CRC_DATA_BYTES
                 && frame_pos < fcf_pkg::HEADER_BYTES + fcf_pkg::CRC_DATA_BYTES + 4)
            trl_word = {trl_word[23:0], b};

        // Saturate the byte count
        if (frame_pos != fcf_pkg::POS_MAX)
            frame_pos = frame_pos + 8'd1;

        if (tail)
        begin
            chan              = hdr_word[3:1];
            v.spacecraft_word = hdr_word;
            v.channel_id      = chan;
            v.channel_match   = (chan == chan_shadow);
            v.length_ok       = (frame_pos == fcf_pkg::FRAME_LEN);
            v.crc_ok          = v.length_ok
                                && ((run_crc ^ fcf_pkg::CRC_XOROUT) == trl_word);
            expected_verdicts.insert(expected_verdicts.size(), v);
            frame_pos = '0;
        end
    endtask

    // Build one frame; chan above 7 leaves the header random. A sealed frame of at least
    // full length carries a correct trailer, a spoilt one has a single bit flipped after it.
    task automatic queue_frame(input int len, input int chan, input bit seal, input bit spoil);
        logic [7:0] fb[$];
        logic [31:0] c;
        byte_slot_t  s;
        int          at;
        for (int i = 0; i < len; i++)
            fb.insert(i, 8'($urandom));
        if (len > 1 && chan < 8)
            fb[1] = {fb[1][7:4], 3'(chan), fb[1][0]};
        if (seal && len >= fcf_pkg::FRAME_BYTES)
        begin
            c = start_shadow;
            for (int i = fcf_pkg::HEADER_BYTES;
                 i < fcf_pkg::HEADER_BYTES + fcf_pkg::CRC_DATA_BYTES; i++)
                c = crc32_update(c, fb[i]);
            c = c ^ fcf_pkg::CRC_XOROUT;
            for (int i = 0; i < 4; i++)
                fb[fcf_pkg::HEADER_BYTES + fcf_pkg::CRC_DATA_BYTES + i] = c[31 - 8*i -: 8];
            if (spoil)
            begin
                at     = int'($urandom_range(fcf_pkg::HEADER_BYTES, fcf_pkg::FRAME_BYTES - 1));
                fb[at] = fb[at] ^ (8'd1 << $urandom_range(0, 7));
            end
        end
        for (int i = 0; i < len; i++)
        begin
            s.value   = fb[i];
            s.tail    = (i == len - 1);
            s.pre_gap = tx_gaps ? int'($urandom_range(0, 3)) : 0;
            pending_bytes.insert(pending_bytes.size(), s);
        end
        queued_bytes += len;
    endtask

    // Short noise frame, on the wanted channel half of the time
    task automatic random_frame();
        int chan;
        chan = $urandom_range(0, 1) ? int'(chan_shadow) : 8;
        queue_frame(int'($urandom_range(1, 30)), chan, 1'b0, 1'b0);
    endtask

    // Hold until every byte is in and every verdict is out, then let the pipeline drain
    task automatic wait_quiet();
        while (pending_bytes.size() != 0 || in_valid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [fcf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == fcf_pkg::CFG_CRC_START)
            start_shadow = val;
        else if (idx == fcf_pkg::CFG_WANTED_CHAN)
            chan_shadow = val[2:0];
        @(negedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fault_count++;
        end
    endtask

    // Byte driver: record each accepted transaction, then offer the next byte
    always @(posedge clk or negedge rst_n)
    begin
        byte_slot_t nxt;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            data_byte <= '0;
            last_byte <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_byte(data_byte, last_byte);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && tx_wait < pending_bytes[0].pre_gap)
                begin
                    tx_wait++;
                    in_valid <= 1'b0;
                end
                else if (pending_bytes.size() != 0)
                begin
                    nxt = pending_bytes[0];
                    pending_bytes.delete(0);
                    tx_wait = 0;
                    in_valid  <= 1'b1;
                    data_byte <= nxt.value;
                    last_byte <= nxt.tail;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Verdict receiver: short random stalls per transaction, plus one long hold on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            rx_wait = 0;
            hold_left = 0;
        end
        else
        begin
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            else if (hold_left > 0)
                hold_left--;
            if (out_valid && !out_stall)
                rx_wait = rx_gaps ? int'($urandom_range(0, 3)) : 0;
            else if (out_valid && rx_wait > 0)
                rx_wait--;
            out_stall <= (hold_left > 0) || (rx_wait > 0);
        end
    end

    // Compare each delivered verdict with the oldest prediction
    always @(posedge clk)
    begin
        fcf_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("verdict with none pending: spacecraft_word 0x%0h", spacecraft_word);
                fault_count++;
            end
            else
            begin
                want = expected_verdicts[0];
                expected_verdicts.delete(0);
                check_field("spacecraft_word", want.spacecraft_word, spacecraft_word);
                check_field("channel_id", 16'(want.channel_id), 16'(channel_id));
                check_field("channel_match", 16'(want.channel_match), 16'(channel_match));
                check_field("length_ok", 16'(want.length_ok), 16'(length_ok));
                check_field("crc_ok", 16'(want.crc_ok), 16'(crc_ok));
            end
        end
    end

    // Watchdog: give up after too long without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [31:0] start_val;
        logic [2:0]  chan_val;
        int          base_bytes;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed frames under the reset register values, no idling:
        // two runts and a sealed over-long frame that saturates the count
        queue_frame(1, 8, 1'b0, 1'b0);
        queue_frame(2, 7, 1'b0, 1'b0);
        queue_frame(260, 1, 1'b1, 1'b0);
        wait_quiet();

        // Phases, each under its own register setting and idling mix
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: begin start_val = '0; chan_val = 3'd0; end
                1: begin start_val = '1; chan_val = 3'd7; end
                2: begin
                    start_val = fcf_pkg::CRC_START_RESET;
                    chan_val  = fcf_pkg::WANTED_CHAN_RESET;
                end
                default: begin start_val = $urandom; chan_val = 3'($urandom); end
            endcase
            write_reg(fcf_pkg::CFG_CRC_START, start_val);
            write_reg(fcf_pkg::CFG_WANTED_CHAN, {29'd0, chan_val});
            if (ph == 2)
            begin
                write_reg(CFG_SPARE_A, $urandom);
                write_reg(CFG_SPARE_B, $urandom);
            end

            tx_gaps = (ph % 4) < 2;
            rx_gaps = (ph % 4) == 0 || (ph % 4) == 2;

            // Back-pressure: hold the receiver while a burst of tiny frames piles up
            if (ph == 3)
            begin
                hold_req++;
                repeat (24) queue_frame(int'($urandom_range(1, 3)), 8, 1'b0, 1'b0);
            end

            // One full sealed frame on the wanted channel, spoilt in the second phase
            base_bytes = queued_bytes;
            queue_frame(fcf_pkg::FRAME_BYTES, int'(chan_val), 1'b1, ph == 1);
            while (queued_bytes - base_bytes < PHASE_BYTES)
                random_frame();
            wait_quiet();
        end

        repeat (10) @(posedge clk);
        if (fault_count == 0 && expected_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
